// File: rtl/i2c_master_transfer_sequencer_core_defines.svh
// Assertion macros shared by the sequencer checkers.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_CORE_DEFINES_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_CORE_DEFINES_SVH

// Check the consequent in the same cycle as the antecedent.
`define I2C_SEQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check the consequent in the cycle after the antecedent.
`define I2C_SEQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/i2c_seq_pkg.sv
package i2c_seq_pkg;

  // Default width of the byte counter and buffer position
  localparam int COUNT_BITS_DEF = 16;

  // Most results one transaction can cause (two-byte read end)
  localparam int MAX_RESULTS = 4;

  // Bytes left at which a read switches to its two-byte ending
  localparam int TWO_LEFT = 2;

  // Command codes
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_EVENT = 2'd1;
  localparam logic [1:0] CMD_ERROR = 2'd2;

  // Engine actions
  localparam logic [2:0] ACT_NONE  = 3'd0;
  localparam logic [2:0] ACT_ADDR  = 3'd1;
  localparam logic [2:0] ACT_DATA  = 3'd2;
  localparam logic [2:0] ACT_START = 3'd3;
  localparam logic [2:0] ACT_STOP  = 3'd4;
  localparam logic [2:0] ACT_STORE = 3'd5;
  localparam logic [2:0] ACT_DONE  = 3'd6;

  // Control field codes for ack, buffer interrupt and event interrupt
  localparam logic [1:0] CTRL_KEEP    = 2'd0;
  localparam logic [1:0] CTRL_ENABLE  = 2'd1;
  localparam logic [1:0] CTRL_DISABLE = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_START,
    PH_ADDR,
    PH_DATA,
    PH_STOP
  } phase_t;

  typedef enum logic [1:0] {
    MODE_RD,
    MODE_WR,
    MODE_WRRD,
    MODE_NONE
  } mode_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [1:0]  access_type;
    logic [7:0]  dev_addr;
    logic [15:0] byte_count;
    logic        flag_sb;
    logic        flag_addr;
    logic        flag_txe;
    logic        flag_btf;
    logic        flag_rxne;
    logic [7:0]  rx_byte;
    logic [7:0]  tx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  action;
    logic        addr_read;
    logic [7:0]  byte_value;
    logic [15:0] byte_index;
    logic [1:0]  ack_ctrl;
    logic        nack_pos_next;
    logic [1:0]  buf_irq_ctrl;
    logic [1:0]  irq_ctrl;
    logic        success;
    logic        last;
  } out_item_t;

endpackage

// File: rtl/i2c_master_transfer_sequencer_core.sv
// Channel  Direction  Handshake            Payload
// in       input      in_valid/in_ready    in_item_t: command, start arguments, bus flags
// out      output     out_valid/out_ready  out_item_t: one engine action, up to four per transaction
//
// An input transaction is captured in an input register and decoded combinationally into
// zero to four results, which load a result buffer; the buffer drains one result per cycle
// while out is ready. The two-byte read end causes the most results, four.
// While the buffer drains or out is stalled, the input register holds one more transaction.
// Reset clears the phase, mode, counters and both registers' valid state.
module i2c_master_transfer_sequencer_core #(
  parameter int COUNT_BITS = i2c_seq_pkg::COUNT_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  i2c_seq_pkg::in_item_t  in_item,
  output logic                   out_valid,
  input  logic                   out_ready,
  output i2c_seq_pkg::out_item_t out_item
);
  import i2c_seq_pkg::*;

  localparam int RCW = $clog2(MAX_RESULTS + 1);
  localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);
  localparam logic [COUNT_BITS-1:0] CNT_TWO = COUNT_BITS'(TWO_LEFT);

  // Input register
  logic     inq_valid;
  in_item_t inq;

  // Result buffer
  out_item_t        batch [MAX_RESULTS];
  logic [RCW-1:0]   batch_cnt;
  out_item_t        res [MAX_RESULTS];
  logic [RCW-1:0]   res_cnt;

  // Transfer state
  phase_t                phase, phase_next;
  mode_t                 mode, mode_next;
  logic [7:0]            taddr, taddr_next;
  logic [COUNT_BITS-1:0] rem, rem_next;
  logic [COUNT_BITS-1:0] pos, pos_next;

  logic                  batch_free;
  logic                  proc;
  logic [COUNT_BITS-1:0] cnt_in;
  logic [COUNT_BITS-1:0] rem_dec;
  logic [COUNT_BITS-1:0] pos_inc;
  logic [15:0]           idx_pos;
  logic [15:0]           idx_pos_inc;
  logic                  start_ok;

  function automatic out_item_t act_item(logic [2:0] act);
    out_item_t r;
    r = '0;
    r.action = act;
    return r;
  endfunction

  function automatic out_item_t done_item(logic ok, logic [1:0] irq);
    out_item_t r;
    r = '0;
    r.action   = ACT_DONE;
    r.irq_ctrl = irq;
    r.success  = ok;
    return r;
  endfunction

  // Handshake and flow control
  assign out_valid  = (batch_cnt != '0);
  assign out_item   = batch[0];
  assign batch_free = (batch_cnt == '0) || ((batch_cnt == RCW'(1)) && out_ready);
  assign proc       = inq_valid && batch_free;
  assign in_ready   = !inq_valid || proc;

  // Shared arithmetic
  assign cnt_in      = inq.byte_count[COUNT_BITS-1:0];
  assign rem_dec     = rem - CNT_ONE;
  assign pos_inc     = pos + CNT_ONE;
  assign idx_pos     = 16'(pos);
  assign idx_pos_inc = 16'(pos_inc);
  assign start_ok    = (phase == PH_IDLE) && (cnt_in != '0) &&
                       (inq.access_type != 2'(MODE_NONE));

  // Next transfer state
  always_comb begin
    phase_next = phase;
    mode_next  = mode;
    taddr_next = taddr;
    rem_next   = rem;
    pos_next   = pos;
    unique case (inq.cmd)
      CMD_START: begin
        if (start_ok) begin
          mode_next  = mode_t'(inq.access_type);
          taddr_next = inq.dev_addr;
          rem_next   = cnt_in;
          pos_next   = '0;
          phase_next = PH_START;
        end
      end
      CMD_EVENT: begin
        unique case (phase)
          PH_START: begin
            if (inq.flag_sb) phase_next = PH_ADDR;
          end
          PH_ADDR: begin
            if (!inq.flag_addr) begin
              phase_next = PH_IDLE;
              mode_next  = MODE_NONE;
            end else begin
              case (mode)
                MODE_RD: phase_next = (rem > CNT_TWO) ? PH_DATA : PH_STOP;
                MODE_WRRD: begin
                  if (inq.flag_txe) phase_next = PH_DATA;
                end
                MODE_WR: begin
                  if (inq.flag_txe) begin
                    rem_next   = rem_dec;
                    pos_next   = pos_inc;
                    phase_next = (rem_dec != '0) ? PH_DATA : PH_STOP;
                  end
                end
                default: ;
              endcase
            end
          end
          PH_DATA: begin
            case (mode)
              MODE_RD: begin
                if (inq.flag_btf) begin
                  rem_next = rem_dec;
                  pos_next = pos_inc;
                  if (rem_dec == CNT_TWO) phase_next = PH_STOP;
                end
              end
              MODE_WR: begin
                if (inq.flag_txe) begin
                  rem_next = rem_dec;
                  pos_next = pos_inc;
                  if (rem_dec == '0) phase_next = PH_STOP;
                end
              end
              MODE_WRRD: begin
                if (inq.flag_txe) begin
                  mode_next  = MODE_RD;
                  phase_next = PH_START;
                end
              end
              default: ;
            endcase
          end
          PH_STOP: begin
            case (mode)
              MODE_RD: begin
                if (rem == CNT_TWO) begin
                  if (inq.flag_btf) begin
                    pos_next   = pos + CNT_TWO;
                    rem_next   = '0;
                    phase_next = PH_IDLE;
                    mode_next  = MODE_NONE;
                  end
                end else if (inq.flag_rxne) begin
                  rem_next   = rem_dec;
                  phase_next = PH_IDLE;
                  mode_next  = MODE_NONE;
                end
              end
              MODE_WR: begin
                if (inq.flag_txe) begin
                  phase_next = PH_IDLE;
                  mode_next  = MODE_NONE;
                end
              end
              default: begin
                phase_next = PH_IDLE;
                mode_next  = MODE_NONE;
              end
            endcase
          end
          default: ;
        endcase
      end
      CMD_ERROR: begin
        if (phase != PH_IDLE) begin
          phase_next = PH_IDLE;
          mode_next  = MODE_NONE;
        end
      end
      default: ;
    endcase
  end

  // Result list for the registered transaction
  always_comb begin
    for (int k = 0; k < MAX_RESULTS; k++) res[k] = '0;
    res_cnt = '0;
    unique case (inq.cmd)
      CMD_START: begin
        res_cnt = RCW'(1);
        if (start_ok) begin
          res[0]          = act_item(ACT_START);
          res[0].irq_ctrl = CTRL_ENABLE;
        end else begin
          res[0] = done_item(1'b0, CTRL_KEEP);
        end
      end
      CMD_EVENT: begin
        unique case (phase)
          PH_START: begin
            if (inq.flag_sb) begin
              res[0]            = act_item(ACT_ADDR);
              res[0].addr_read  = (mode == MODE_RD);
              res[0].byte_value = taddr;
              res_cnt           = RCW'(1);
            end
          end
          PH_ADDR: begin
            if (!inq.flag_addr) begin
              res[0]              = act_item(ACT_STOP);
              res[0].buf_irq_ctrl = CTRL_DISABLE;
              res[0].irq_ctrl     = CTRL_DISABLE;
              res[1]              = done_item(rem == '0, CTRL_DISABLE);
              res_cnt             = RCW'(2);
            end else begin
              case (mode)
                MODE_RD: begin
                  res[0]  = act_item(ACT_NONE);
                  res_cnt = RCW'(1);
                  if (rem > CNT_TWO) begin
                    res[0].ack_ctrl = CTRL_ENABLE;
                  end else if (rem == CNT_TWO) begin
                    res[0].ack_ctrl      = CTRL_DISABLE;
                    res[0].nack_pos_next = 1'b1;
                  end else begin
                    res[0].buf_irq_ctrl = CTRL_ENABLE;
                    res[0].ack_ctrl     = CTRL_DISABLE;
                  end
                end
                MODE_WR, MODE_WRRD: begin
                  if (inq.flag_txe) begin
                    res[0]            = act_item(ACT_DATA);
                    res[0].byte_value = inq.tx_byte;
                    res[0].byte_index = idx_pos;
                    res_cnt           = RCW'(1);
                  end
                end
                default: ;
              endcase
            end
          end
          PH_DATA: begin
            case (mode)
              MODE_RD: begin
                if (inq.flag_btf) begin
                  res[0]            = act_item(ACT_STORE);
                  res[0].byte_value = inq.rx_byte;
                  res[0].byte_index = idx_pos;
                  if (rem_dec == CNT_TWO) res[0].ack_ctrl = CTRL_DISABLE;
                  res_cnt = RCW'(1);
                end
              end
              MODE_WR: begin
                if (inq.flag_txe) begin
                  res[0]            = act_item(ACT_DATA);
                  res[0].byte_value = inq.tx_byte;
                  res[0].byte_index = idx_pos;
                  res_cnt           = RCW'(1);
                end
              end
              MODE_WRRD: begin
                if (inq.flag_txe) begin
                  res[0]  = act_item(ACT_START);
                  res_cnt = RCW'(1);
                end
              end
              default: ;
            endcase
          end
          PH_STOP: begin
            case (mode)
              MODE_RD: begin
                if (rem == CNT_TWO) begin
                  if (inq.flag_btf) begin
                    res[0]            = act_item(ACT_STOP);
                    res[1]            = act_item(ACT_STORE);
                    res[1].byte_value = inq.rx_byte;
                    res[1].byte_index = idx_pos;
                    res[2]            = act_item(ACT_STORE);
                    res[2].byte_value = inq.rx_byte;
                    res[2].byte_index = idx_pos_inc;
                    res[3]            = done_item(1'b1, CTRL_DISABLE);
                    res_cnt           = RCW'(4);
                  end
                end else if (inq.flag_rxne) begin
                  res[0]              = act_item(ACT_STOP);
                  res[1]              = act_item(ACT_STORE);
                  res[1].byte_value   = inq.rx_byte;
                  res[1].byte_index   = idx_pos;
                  res[1].buf_irq_ctrl = CTRL_DISABLE;
                  res[2]              = done_item(rem_dec == '0, CTRL_DISABLE);
                  res_cnt             = RCW'(3);
                end
              end
              MODE_WR: begin
                if (inq.flag_txe) begin
                  res[0]  = act_item(ACT_STOP);
                  res[1]  = done_item(rem == '0, CTRL_DISABLE);
                  res_cnt = RCW'(2);
                end
              end
              default: begin
                res[0]  = done_item(rem == '0, CTRL_DISABLE);
                res_cnt = RCW'(1);
              end
            endcase
          end
          default: ;
        endcase
      end
      CMD_ERROR: begin
        if (phase != PH_IDLE) begin
          res[0]              = act_item(ACT_STOP);
          res[0].buf_irq_ctrl = CTRL_DISABLE;
          res[0].irq_ctrl     = CTRL_DISABLE;
          res[1]              = done_item(rem == '0, CTRL_DISABLE);
          res_cnt             = RCW'(2);
        end
      end
      default: ;
    endcase
    // Mark the final result of the transaction
    for (int k = 0; k < MAX_RESULTS; k++) begin
      res[k].last = (RCW'(k) == res_cnt - RCW'(1));
    end
  end

  // Capture the next input transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
    end else if (in_ready) begin
      inq_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      inq <= in_item;
    end
  end

  // Advance transfer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      mode  <= MODE_NONE;
      taddr <= '0;
      rem   <= '0;
      pos   <= '0;
    end else if (proc) begin
      phase <= phase_next;
      mode  <= mode_next;
      taddr <= taddr_next;
      rem   <= rem_next;
      pos   <= pos_next;
    end
  end

  // Load or drain the result buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      batch_cnt <= '0;
    end else if (proc) begin
      batch_cnt <= res_cnt;
    end else if (out_valid && out_ready) begin
      batch_cnt <= batch_cnt - RCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      for (int k = 0; k < MAX_RESULTS; k++) batch[k] <= res[k];
    end else if (out_valid && out_ready) begin
      for (int k = 0; k < MAX_RESULTS - 1; k++) batch[k] <= batch[k + 1];
    end
  end

endmodule

// File: rtl/i2c_seq_checker.sv
`include "i2c_master_transfer_sequencer_core_defines.svh"

module i2c_seq_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   out_valid,
  input logic                   out_ready,
  input i2c_seq_pkg::out_item_t out_item
);
  import i2c_seq_pkg::*;

  // Hold a stalled result
  `I2C_SEQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item), "stalled result changed")

  // A done result must be the last result of its transaction
  `I2C_SEQ_ASSERT_NOW(a_done_last, out_valid && (out_item.action == ACT_DONE), out_item.last, "done result not last")

  // Accept a transfer start with a single result
  `I2C_SEQ_ASSERT_NOW(a_start_single, out_valid && (out_item.action == ACT_START) && (out_item.irq_ctrl == CTRL_ENABLE), out_item.last, "accepted start not single")

  // Follow a non-final result directly with the next one
  `I2C_SEQ_ASSERT_NEXT(a_burst, out_valid && out_ready && !out_item.last, out_valid, "gap inside a result burst")

  // Report success only on done
  `I2C_SEQ_ASSERT_NOW(a_success_done, out_valid && (out_item.action != ACT_DONE), !out_item.success, "success outside done")

endmodule

bind i2c_master_transfer_sequencer_core i2c_seq_checker u_i2c_seq_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

// File: bench/i2c_seq_action_monitor.sv
module i2c_seq_action_monitor
  import i2c_seq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_item,
  output int        mismatches,
  output int        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REPORTS = 10;
  localparam logic [15:0] LEFT_TWO = 16'(TWO_LEFT);

  // Shadow of the sequencer state
  phase_t      xfer_phase;
  mode_t       xfer_mode;
  logic [7:0]  xfer_addr;
  logic [15:0] bytes_left;
  logic [15:0] buf_pos;

  out_item_t caused[$];
  out_item_t expected_actions[$];

  function automatic out_item_t mk_action(input logic [2:0] act, input logic [7:0] value,
                                          input logic [15:0] index);
    out_item_t r;
    r = '0;
    r.action = act;
    r.byte_value = value;
    r.byte_index = index;
    return r;
  endfunction

  function automatic string describe(input out_item_t r);
    return $sformatf("{act %0d rd %0b val %02h idx %0d ack %0d np %0b bi %0d irq %0d ok %0b last %0b}",
                     r.action, r.addr_read, r.byte_value, r.byte_index, r.ack_ctrl,
                     r.nack_pos_next, r.buf_irq_ctrl, r.irq_ctrl, r.success, r.last);
  endfunction

  // Close the transfer: done with interrupts off, then back to idle
  task automatic finish_xfer();
    out_item_t r;
    r = mk_action(ACT_DONE, 8'h00, 16'h0000);
    r.irq_ctrl = CTRL_DISABLE;
    r.success = (bytes_left == 16'h0000);
    caused.push_back(r);
    xfer_phase = PH_IDLE;
    xfer_mode = MODE_NONE;
  endtask

  task automatic abort_xfer();
    out_item_t r;
    r = mk_action(ACT_STOP, 8'h00, 16'h0000);
    r.buf_irq_ctrl = CTRL_DISABLE;
    r.irq_ctrl = CTRL_DISABLE;
    caused.push_back(r);
    finish_xfer();
  endtask

  task automatic bus_event(input in_item_t t);
    out_item_t r;
    case (xfer_phase)
      PH_START: begin
        if (t.flag_sb) begin
          r = mk_action(ACT_ADDR, xfer_addr, 16'h0000);
          r.addr_read = (xfer_mode == MODE_RD);
          caused.push_back(r);
          xfer_phase = PH_ADDR;
        end
      end
      PH_ADDR: begin
        if (!t.flag_addr) begin
          abort_xfer();
        end else if (xfer_mode == MODE_RD) begin
          // pick the read ending by how many bytes are left
          r = mk_action(ACT_NONE, 8'h00, 16'h0000);
          if (bytes_left > LEFT_TWO) begin
            r.ack_ctrl = CTRL_ENABLE;
            xfer_phase = PH_DATA;
          end else if (bytes_left == LEFT_TWO) begin
            r.ack_ctrl = CTRL_DISABLE;
            r.nack_pos_next = 1'b1;
            xfer_phase = PH_STOP;
          end else begin
            r.buf_irq_ctrl = CTRL_ENABLE;
            r.ack_ctrl = CTRL_DISABLE;
            xfer_phase = PH_STOP;
          end
          caused.push_back(r);
        end else if (xfer_mode == MODE_WRRD) begin
          // first byte of a combined transfer does not consume the count
          if (t.flag_txe) begin
            caused.push_back(mk_action(ACT_DATA, t.tx_byte, buf_pos));
            xfer_phase = PH_DATA;
          end
        end else if (xfer_mode == MODE_WR) begin
          if (t.flag_txe) begin
            caused.push_back(mk_action(ACT_DATA, t.tx_byte, buf_pos));
            bytes_left = bytes_left - 16'd1;
            buf_pos = buf_pos + 16'd1;
            xfer_phase = (bytes_left != 16'h0000) ? PH_DATA : PH_STOP;
          end
        end
      end
      PH_DATA: begin
        if (xfer_mode == MODE_RD) begin
          if (t.flag_btf) begin
            r = mk_action(ACT_STORE, t.rx_byte, buf_pos);
            bytes_left = bytes_left - 16'd1;
            buf_pos = buf_pos + 16'd1;
            if (bytes_left == LEFT_TWO) begin
              r.ack_ctrl = CTRL_DISABLE;
              xfer_phase = PH_STOP;
            end
            caused.push_back(r);
          end
        end else if (xfer_mode == MODE_WR) begin
          if (t.flag_txe) begin
            caused.push_back(mk_action(ACT_DATA, t.tx_byte, buf_pos));
            bytes_left = bytes_left - 16'd1;
            buf_pos = buf_pos + 16'd1;
            if (bytes_left == 16'h0000) xfer_phase = PH_STOP;
          end
        end else if (xfer_mode == MODE_WRRD) begin
          // turn around into the read with a repeated start
          if (t.flag_txe) begin
            xfer_mode = MODE_RD;
            xfer_phase = PH_START;
            caused.push_back(mk_action(ACT_START, 8'h00, 16'h0000));
          end
        end
      end
      PH_STOP: begin
        if (xfer_mode == MODE_RD) begin
          if (bytes_left == LEFT_TWO) begin
            // two-byte end stores the same register byte twice
            if (t.flag_btf) begin
              caused.push_back(mk_action(ACT_STOP, 8'h00, 16'h0000));
              caused.push_back(mk_action(ACT_STORE, t.rx_byte, buf_pos));
              caused.push_back(mk_action(ACT_STORE, t.rx_byte, buf_pos + 16'd1));
              buf_pos = buf_pos + 16'd2;
              bytes_left = bytes_left - 16'd2;
              finish_xfer();
            end
          end else if (t.flag_rxne) begin
            caused.push_back(mk_action(ACT_STOP, 8'h00, 16'h0000));
            r = mk_action(ACT_STORE, t.rx_byte, buf_pos);
            r.buf_irq_ctrl = CTRL_DISABLE;
            caused.push_back(r);
            bytes_left = bytes_left - 16'd1;
            finish_xfer();
          end
        end else if (xfer_mode == MODE_WR) begin
          if (t.flag_txe) begin
            caused.push_back(mk_action(ACT_STOP, 8'h00, 16'h0000));
            finish_xfer();
          end
        end else begin
          finish_xfer();
        end
      end
      default: ;
    endcase
  endtask

  // Work out every result one input transaction causes
  task automatic predict_actions(input in_item_t t);
    out_item_t r;
    caused.delete();
    case (t.cmd)
      CMD_START: begin
        if (xfer_phase != PH_IDLE || t.byte_count == 16'h0000 || t.access_type > MODE_WRRD) begin
          caused.push_back(mk_action(ACT_DONE, 8'h00, 16'h0000));
        end else begin
          xfer_mode = mode_t'(t.access_type);
          xfer_addr = t.dev_addr;
          bytes_left = t.byte_count;
          buf_pos = 16'h0000;
          xfer_phase = PH_START;
          r = mk_action(ACT_START, 8'h00, 16'h0000);
          r.irq_ctrl = CTRL_ENABLE;
          caused.push_back(r);
        end
      end
      CMD_EVENT: bus_event(t);
      CMD_ERROR: if (xfer_phase != PH_IDLE) abort_xfer();
      default: ;
    endcase
    if (caused.size() > 0) caused[caused.size() - 1].last = 1'b1;
    foreach (caused[i]) expected_actions.push_back(caused[i]);
  endtask

  // Sample both channels mid-cycle, ahead of the edge that accepts them
  always @(negedge clk) begin
    out_item_t want;
    if (rst) begin
      xfer_phase = PH_IDLE;
      xfer_mode = MODE_NONE;
      xfer_addr = 8'h00;
      bytes_left = 16'h0000;
      buf_pos = 16'h0000;
      expected_actions.delete();
      mismatches = 0;
    end else begin
      if (in_valid && in_ready) predict_actions(in_item);
      if (out_valid && out_ready) begin
        if (expected_actions.size() == 0) begin
          if (mismatches < MAX_REPORTS)
            $display("%0t: unexpected result %s", $time, describe(out_item));
          mismatches++;
        end else begin
          want = expected_actions.pop_front();
          if (out_item !== want) begin
            if (mismatches < MAX_REPORTS)
              $display("%0t: result mismatch, expected %s got %s", $time, describe(want),
                       describe(out_item));
            mismatches++;
          end
        end
      end
    end
    pending = expected_actions.size();
  end

endmodule

// File: bench/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import i2c_seq_pkg::*;

  localparam int          DRAIN_CYCLES = 8;
  localparam int          DRAIN_LIMIT  = 50000;
  localparam int          LEG_ITEMS    = 150;
  localparam logic [1:0]  CMD_UNUSED   = 2'd3;
  localparam logic [4:0]  F_SB         = 5'b10000;
  localparam logic [4:0]  F_ADDR       = 5'b01000;
  localparam logic [4:0]  F_TXE        = 5'b00100;
  localparam logic [4:0]  F_BTF        = 5'b00010;
  localparam logic [4:0]  F_RXNE       = 5'b00001;
  localparam logic [4:0]  ALL_FLAGS    = 5'b11111;

  logic      clk;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  int send_idle = 27;
  int recv_idle = 46;
  int sent = 0;
  int mismatches;
  int pending;

  i2c_master_transfer_sequencer_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  i2c_seq_action_monitor action_monitor (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Stall the result channel at the current rate
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  function automatic in_item_t noise_item();
    in_item_t it;
    it.cmd = 2'($urandom_range(3));
    it.access_type = 2'($urandom_range(3));
    it.dev_addr = 8'($urandom_range(255));
    it.byte_count = 16'($urandom_range(65535));
    {it.flag_sb, it.flag_addr, it.flag_txe, it.flag_btf, it.flag_rxne} = 5'($urandom_range(31));
    it.rx_byte = 8'($urandom_range(255));
    it.tx_byte = 8'($urandom_range(255));
    return it;
  endfunction

  function automatic in_item_t start_item(input logic [1:0] kind, input logic [7:0] addr,
                                          input logic [15:0] count);
    in_item_t it;
    it = noise_item();
    it.cmd = CMD_START;
    it.access_type = kind;
    it.dev_addr = addr;
    it.byte_count = count;
    return it;
  endfunction

  function automatic in_item_t event_item(input logic [4:0] flags);
    in_item_t it;
    it = noise_item();
    it.cmd = CMD_EVENT;
    {it.flag_sb, it.flag_addr, it.flag_txe, it.flag_btf, it.flag_rxne} = flags;
    return it;
  endfunction

  function automatic in_item_t error_item();
    in_item_t it;
    it = noise_item();
    it.cmd = CMD_ERROR;
    return it;
  endfunction

  // Offer one transaction after a random gap and hold it until accepted
  task automatic send_item(input in_item_t it);
    logic took;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    sent++;
  endtask

  // Hold off the sender until every expected result is out
  task automatic drain();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Well-formed transfer, mostly with every flag up, now and then a noisy event
  task automatic run_transfer();
    logic [1:0]  kind;
    logic [15:0] count;
    int          steps;
    bit          noisy;
    kind = 2'($urandom_range(2));
    count = 16'(($urandom_range(99) < 85) ? $urandom_range(1, 6) : $urandom_range(7, 24));
    if (kind == MODE_RD) steps = ((count < 2) ? 2 : count) + 1;
    else if (kind == MODE_WR) steps = count + 2;
    else steps = ((count < 2) ? 2 : count) + 4;
    noisy = 1'b0;
    send_item(start_item(kind, 8'($urandom_range(255)), count));
    repeat (steps) begin
      if ($urandom_range(99) < 6) begin
        noisy = 1'b1;
        send_item(event_item(5'($urandom_range(31))));
      end else begin
        send_item(event_item(ALL_FLAGS));
      end
    end
    // clean up a transfer the noise may have left hanging
    if (noisy) send_item(error_item());
  endtask

  // Start with any count or type, a few events, maybe a busy start, then an error
  task automatic run_broken();
    send_item(start_item(2'($urandom_range(3)), 8'($urandom_range(255)),
                         16'($urandom_range(65535))));
    repeat ($urandom_range(3)) begin
      send_item(event_item(($urandom_range(1)) ? ALL_FLAGS : 5'($urandom_range(31))));
    end
    if ($urandom_range(99) < 30)
      send_item(start_item(2'($urandom_range(3)), 8'($urandom_range(255)),
                           16'($urandom_range(65535))));
    send_item(error_item());
  endtask

  initial begin
    in_item_t it;
    int       goal;
    int       pick;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Rejected starts and items with no effect while idle
    send_item(start_item(MODE_RD, 8'h5A, 16'h0000));
    send_item(start_item(MODE_NONE, 8'hA5, 16'd3));
    it = noise_item();
    it.cmd = CMD_UNUSED;
    send_item(it);
    send_item(event_item(ALL_FLAGS));
    send_item(error_item());

    // Largest count, start while busy, abort
    send_item(start_item(MODE_WR, 8'h00, 16'hFFFF));
    send_item(start_item(MODE_RD, 8'h11, 16'd1));
    send_item(error_item());

    // Single-byte write aborted after its byte went out: success stays set
    send_item(start_item(MODE_WR, 8'hFF, 16'd1));
    send_item(event_item(F_SB));
    send_item(event_item(F_ADDR | F_TXE));
    send_item(error_item());

    // Address not acknowledged
    send_item(start_item(MODE_RD, 8'h3C, 16'd2));
    send_item(event_item(F_SB));
    send_item(event_item(F_TXE | F_BTF | F_RXNE));

    // Write one byte then read one byte, with an event that misses its flag
    send_item(start_item(MODE_WRRD, 8'hC3, 16'd1));
    send_item(event_item(F_ADDR | F_TXE));
    send_item(event_item(F_SB));
    send_item(event_item(F_ADDR | F_TXE));
    send_item(event_item(F_TXE));
    send_item(event_item(F_SB));
    send_item(event_item(F_ADDR));
    send_item(event_item(F_RXNE));

    // Random legs: receiver idles more, then sender idles more, then no idling
    for (int leg = 0; leg < 3; leg++) begin
      send_idle = (leg == 0) ? 27 : (leg == 1) ? 46 : 0;
      recv_idle = (leg == 0) ? 46 : (leg == 1) ? 27 : 0;
      goal = sent + LEG_ITEMS;
      while (sent < goal) begin
        pick = $urandom_range(99);
        if (pick < 80) run_transfer();
        else if (pick < 90) run_broken();
        else send_item(noise_item());
      end
      if (leg == 0) drain();
    end

    drain();
    if (mismatches == 0 && pending == 0) begin
      $display("i2c_master_transfer_sequencer_core regression: pass");
    end else begin
      $display("i2c_master_transfer_sequencer_core regression: fail");
    end
    $finish;
  end

  // Give up on a hung run
  initial begin
    #2_000_000;
    $display("i2c_master_transfer_sequencer_core regression: fail");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/i2c_seq_pkg.sv
rtl/i2c_master_transfer_sequencer_core.sv
rtl/i2c_seq_checker.sv
bench/i2c_seq_action_monitor.sv
bench/tb.sv
